/* rtl/core/pgh_pkg.sv */
// Package for the polar grid height binning block: grid geometry, cell
// layout, register indexes, opcodes, sequencer states and the arctangent table.
// No dependencies.
package pgh_pkg;

  localparam int NUM_SECTORS    = 180;
  localparam int NUM_BINS       = 160;
  localparam int OUTER_BIN_BASE = 100;
  localparam int CELLS          = NUM_SECTORS * NUM_BINS;
  localparam int CELL_AW        = $clog2(CELLS);
  localparam int ROT_STEPS      = 28;
  localparam int ROT_IW         = $clog2(ROT_STEPS);
  localparam int SQRT_STEPS     = 17;
  localparam int DIV_STEPS      = 17;
  localparam int SEC_PW         = 32 + $clog2(NUM_SECTORS + 1);

  localparam int Z_W    = 16;
  localparam int RNG_W  = 17;
  localparam int CELL_W = 1 + Z_W + RNG_W + Z_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] CFG_INNER_STEP = 2'd0;
  localparam logic [1:0] CFG_SPLIT      = 2'd1;
  localparam logic [1:0] CFG_OUTER_STEP = 2'd2;

  typedef struct packed {
    logic              seen;
    logic signed [Z_W-1:0] min_z;
    logic [RNG_W-1:0]  min_range;
    logic signed [Z_W-1:0] max_z;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{seen: 1'b0, min_z: 16'sh7FFF,
                                   min_range: '0, max_z: 16'sh8000};

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_ATAN  = 10'b0000100000,
    S_SECT  = 10'b0001000000,
    S_ADDR  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  // atan(2^-i) in units of 2^32 per full turn.
  function automatic logic [31:0] atan_lut(input logic [ROT_IW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/pgh_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module pgh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/polar_grid_height_binning.sv */
// Polar grid height map: sequencer with shared multiplier, square root,
// divider and vectoring rotation steps. Uses pgh_pkg and pgh_ram.
//
// Each request takes a start pulse while busy is low. An insert runs from
// acceptance to the result strobe through the multiplies, 17 square root
// steps, 17 divide steps, 28 rotation steps and the sector, cell read and
// finishing states; the iteration counts of those shared units set the rate.
// A read passes only the cell read and finishing states. Each request gives
// exactly one result, valid for one cycle on out_valid, which the receiver must
// take. After reset the cell store is cleared one entry per cycle, all 28800
// cells, with busy high; register writes are taken throughout.
module polar_grid_height_binning (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic signed [16:0] in_x_mm,
  input  logic signed [16:0] in_y_mm,
  input  logic signed [15:0] in_z_mm,
  input  logic [7:0]         in_sector_sel,
  input  logic [7:0]         in_bin_sel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic [7:0]         out_sector,
  output logic [7:0]         out_bin,
  output logic               out_cell_seen,
  output logic signed [15:0] out_cell_min_z,
  output logic [16:0]        out_cell_min_range,
  output logic signed [15:0] out_cell_max_z
);

  pgh_pkg::state_t state_r, state_nxt;
  logic [pgh_pkg::CELL_AW-1:0] cnt_r, cnt_nxt;

  logic [9:0]  inner_r;
  logic [15:0] split_r;
  logic [10:0] outer_r;

  logic               op_r;
  logic signed [16:0] x_r, y_r;
  logic signed [15:0] z_r;
  logic [7:0]         sec_r, sec_nxt;
  logic [7:0]         bin_r, bin_nxt;
  logic               oob_r, oob_nxt;
  logic [33:0]        acc_r, acc_nxt;
  logic               inner_sel_r, inner_sel_nxt;
  logic [19:0]        srem_r, srem_nxt;
  logic [16:0]        root_r, root_nxt;
  logic [16:0]        dvd_r, dvd_nxt;
  logic [11:0]        drem_r, drem_nxt;
  logic signed [34:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0]        ang_r, ang_nxt;

  logic [16:0] mul_a, mul_b, abs_x, abs_y;
  logic [33:0] prod;
  logic [19:0] srem_t, stest;
  logic [11:0] drem_t, step_ext;
  logic [10:0] step_eff;
  logic        dge;
  logic [16:0] q_fin;
  logic [17:0] bin_raw;
  logic signed [34:0] cx0, cy0, sx, sy;
  logic [31:0] ang_u;
  logic [pgh_pkg::SEC_PW-1:0] sec_prod;
  logic [pgh_pkg::SEC_PW-33:0] sec_raw;

  logic ram_we, ram_re;
  logic [pgh_pkg::CELL_AW-1:0] ram_waddr, ram_raddr, cell_addr;
  pgh_pkg::cell_t ram_wdata, ram_rdata, cell_upd;
  logic [pgh_pkg::CELL_W-1:0] ram_rbits;

  logic               out_valid_r;
  logic [7:0]         out_sector_r, out_bin_r;
  pgh_pkg::cell_t     out_cell_r;

  assign busy = (state_r != pgh_pkg::S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= 10'd200;
      split_r <= 16'd20000;
      outer_r <= 11'd500;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pgh_pkg::CFG_INNER_STEP: inner_r <= cfg_wdata[9:0];
        pgh_pkg::CFG_SPLIT:      split_r <= cfg_wdata;
        pgh_pkg::CFG_OUTER_STEP: outer_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Shared 17x17 multiplier on magnitudes.
  assign abs_x = x_r[16] ? 17'(-x_r) : 17'(x_r);
  assign abs_y = y_r[16] ? 17'(-y_r) : 17'(y_r);
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin mul_a = abs_x;          mul_b = abs_x;          end
      2'd1:    begin mul_a = abs_y;          mul_b = abs_y;          end
      default: begin mul_a = {1'b0, split_r}; mul_b = {1'b0, split_r}; end
    endcase
  end
  assign prod = 34'(mul_a) * 34'(mul_b);

  // One square root digit: two radicand bits per step.
  assign srem_t = {srem_r[17:0], acc_r[33:32]};
  assign stest  = {1'b0, root_r, 2'b01};

  // One restoring divide step.
  assign step_eff = inner_sel_r ? ((inner_r == '0) ? 11'd1 : {1'b0, inner_r})
                                : ((outer_r == '0) ? 11'd1 : outer_r);
  assign step_ext = {1'b0, step_eff};
  assign drem_t   = {drem_r[10:0], dvd_r[16]};
  assign dge      = (drem_t >= step_ext);
  assign q_fin    = {dvd_r[15:0], dge};
  assign bin_raw  = inner_sel_r ? 18'(q_fin)
                                : 18'(q_fin) + 18'(pgh_pkg::OUTER_BIN_BASE);

  // Rotation start and shifted terms.
  assign cx0 = x_r[16] ? -(35'(x_r) <<< 14) : (35'(x_r) <<< 14);
  assign cy0 = x_r[16] ? -(35'(y_r) <<< 14) : (35'(y_r) <<< 14);
  assign sx  = cx_r >>> cnt_r[pgh_pkg::ROT_IW-1:0];
  assign sy  = cy_r >>> cnt_r[pgh_pkg::ROT_IW-1:0];

  assign ang_u    = ang_r + 32'h8000_0000;
  assign sec_prod = pgh_pkg::SEC_PW'(ang_u) * pgh_pkg::SEC_PW'(pgh_pkg::NUM_SECTORS);
  assign sec_raw  = sec_prod[pgh_pkg::SEC_PW-1:32];

  assign cell_addr = pgh_pkg::CELL_AW'(sec_r) * pgh_pkg::CELL_AW'(pgh_pkg::NUM_BINS)
                   + pgh_pkg::CELL_AW'(bin_r);

  assign ram_rdata = pgh_pkg::cell_t'(ram_rbits);

  always_comb begin
    cell_upd      = ram_rdata;
    cell_upd.seen = 1'b1;
    if (z_r < ram_rdata.min_z) begin
      cell_upd.min_z     = z_r;
      cell_upd.min_range = root_r;
    end
    if (z_r > ram_rdata.max_z) begin
      cell_upd.max_z = z_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sec_nxt       = sec_r;
    bin_nxt       = bin_r;
    oob_nxt       = oob_r;
    acc_nxt       = acc_r;
    inner_sel_nxt = inner_sel_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    dvd_nxt       = dvd_r;
    drem_nxt      = drem_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ang_nxt       = ang_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = cell_upd;
    ram_re        = 1'b0;
    ram_raddr     = cell_addr;
    unique case (state_r)
      pgh_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = pgh_pkg::CELL_EMPTY;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == pgh_pkg::CELL_AW'(pgh_pkg::CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = pgh_pkg::S_IDLE;
        end
      end
      pgh_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          if (in_opcode == pgh_pkg::OP_READ) begin
            sec_nxt   = in_sector_sel;
            bin_nxt   = in_bin_sel;
            oob_nxt   = (in_sector_sel >= 8'(pgh_pkg::NUM_SECTORS)) ||
                        (in_bin_sel >= 8'(pgh_pkg::NUM_BINS));
            state_nxt = pgh_pkg::S_ADDR;
          end else begin
            oob_nxt   = 1'b0;
            state_nxt = pgh_pkg::S_MUL;
          end
        end
      end
      pgh_pkg::S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[1:0])
          2'd0: acc_nxt = prod;
          2'd1: acc_nxt = acc_r + prod;
          default: begin
            inner_sel_nxt = (acc_r < prod);
            srem_nxt      = '0;
            root_nxt      = '0;
            cnt_nxt       = '0;
            state_nxt     = pgh_pkg::S_SQRT;
          end
        endcase
      end
      pgh_pkg::S_SQRT: begin
        acc_nxt = {acc_r[31:0], 2'b00};
        if (srem_t >= stest) begin
          srem_nxt = srem_t - stest;
          root_nxt = {root_r[15:0], 1'b1};
        end else begin
          srem_nxt = srem_t;
          root_nxt = {root_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pgh_pkg::CELL_AW'(pgh_pkg::SQRT_STEPS - 1)) begin
          dvd_nxt   = inner_sel_r ? root_nxt : root_nxt - 17'(split_r);
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = pgh_pkg::S_DIV;
        end
      end
      pgh_pkg::S_DIV: begin
        drem_nxt = dge ? drem_t - step_ext : drem_t;
        dvd_nxt  = q_fin;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == pgh_pkg::CELL_AW'(pgh_pkg::DIV_STEPS - 1)) begin
          bin_nxt   = (bin_raw > 18'(pgh_pkg::NUM_BINS - 1))
                    ? 8'(pgh_pkg::NUM_BINS - 1) : bin_raw[7:0];
          cx_nxt    = cx0;
          cy_nxt    = cy0;
          ang_nxt   = x_r[16] ? 32'h8000_0000 : 32'h0;
          cnt_nxt   = '0;
          state_nxt = pgh_pkg::S_ATAN;
        end
      end
      pgh_pkg::S_ATAN: begin
        // A vector already on the axis stays put for the remaining steps.
        if (cy_r > 0) begin
          cx_nxt  = cx_r + sy;
          cy_nxt  = cy_r - sx;
          ang_nxt = ang_r + pgh_pkg::atan_lut(cnt_r[pgh_pkg::ROT_IW-1:0]);
        end else if (cy_r < 0) begin
          cx_nxt  = cx_r - sy;
          cy_nxt  = cy_r + sx;
          ang_nxt = ang_r - pgh_pkg::atan_lut(cnt_r[pgh_pkg::ROT_IW-1:0]);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pgh_pkg::CELL_AW'(pgh_pkg::ROT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = pgh_pkg::S_SECT;
        end
      end
      pgh_pkg::S_SECT: begin
        sec_nxt   = (sec_raw >= 9'(pgh_pkg::NUM_SECTORS))
                  ? 8'(pgh_pkg::NUM_SECTORS - 1) : sec_raw[7:0];
        state_nxt = pgh_pkg::S_ADDR;
      end
      pgh_pkg::S_ADDR: begin
        ram_re    = !oob_r;
        state_nxt = pgh_pkg::S_FIN;
      end
      pgh_pkg::S_FIN: begin
        ram_we    = (op_r == pgh_pkg::OP_INSERT);
        state_nxt = pgh_pkg::S_IDLE;
      end
      default: state_nxt = pgh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgh_pkg::S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == pgh_pkg::S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pgh_pkg::S_IDLE && start) begin
      op_r <= in_opcode;
      x_r  <= in_x_mm;
      y_r  <= in_y_mm;
      z_r  <= in_z_mm;
    end
    sec_r       <= sec_nxt;
    bin_r       <= bin_nxt;
    oob_r       <= oob_nxt;
    acc_r       <= acc_nxt;
    inner_sel_r <= inner_sel_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    dvd_r       <= dvd_nxt;
    drem_r      <= drem_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    ang_r       <= ang_nxt;
    if (state_r == pgh_pkg::S_FIN) begin
      out_sector_r <= sec_r;
      out_bin_r    <= bin_r;
      if (oob_r) begin
        out_cell_r <= pgh_pkg::CELL_EMPTY;
      end else if (op_r == pgh_pkg::OP_INSERT) begin
        out_cell_r <= cell_upd;
      end else begin
        out_cell_r <= ram_rdata;
      end
    end
  end

  pgh_ram #(
    .WIDTH(pgh_pkg::CELL_W),
    .DEPTH(pgh_pkg::CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign out_valid          = out_valid_r;
  assign out_sector         = out_sector_r;
  assign out_bin            = out_bin_r;
  assign out_cell_seen      = out_cell_r.seen;
  assign out_cell_min_z     = out_cell_r.min_z;
  assign out_cell_min_range = out_cell_r.min_range;
  assign out_cell_max_z     = out_cell_r.max_z;

`ifndef SYNTHESIS
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == pgh_pkg::S_FIN))
    else $error("result strobe without a finishing cycle");

  a_insert_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == pgh_pkg::OP_INSERT) |-> out_cell_seen)
    else $error("inserted point left its cell unseen");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < pgh_pkg::CELL_AW'(pgh_pkg::CELLS)))
    else $error("cell write beyond the grid");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgh_pkg::S_CLEAR) |-> busy)
    else $error("request possible during store clearing");
`endif

endmodule

/* test/polar_grid_height_binning_tb.sv */
// Testbench for polar_grid_height_binning: drives insert and read requests and
// checks every result against an in-bench polar height map predictor.
// Depends on pgh_pkg and the block under test.
module polar_grid_height_binning_tb;

  typedef struct {
    logic [7:0]         sector;
    logic [7:0]         bin;
    logic               seen;
    logic signed [15:0] min_z;
    logic [16:0]        min_range;
    logic signed [15:0] max_z;
  } cell_report_t;

  class height_map_scoreboard;
    logic [9:0]         inner_step;
    logic [15:0]        split_radius;
    logic [10:0]        outer_step;
    logic signed [15:0] low_z [pgh_pkg::CELLS];
    logic [16:0]        low_rng [pgh_pkg::CELLS];
    logic signed [15:0] high_z [pgh_pkg::CELLS];
    logic               hit [pgh_pkg::CELLS];
    cell_report_t       pending [$];
    int                 errors;
    int                 results_seen;
    int                 inserts;
    int                 reads;
    bit [31:0]          rot_tab [28];

    function new();
      inner_step   = 10'd200;
      split_radius = 16'd20000;
      outer_step   = 11'd500;
      errors = 0;
      results_seen = 0;
      inserts = 0;
      reads = 0;
      rot_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                  83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                  81, 41, 20, 10, 5};
      for (int i = 0; i < pgh_pkg::CELLS; i++) begin
        low_z[i]   = 16'sh7FFF;
        low_rng[i] = '0;
        high_z[i]  = 16'sh8000;
        hit[i]     = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        pgh_pkg::CFG_INNER_STEP: inner_step = val[9:0];
        pgh_pkg::CFG_SPLIT:      split_radius = val;
        pgh_pkg::CFG_OUTER_STEP: outer_step = val[10:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, t;
      res = 0;
      for (int b = 17; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (t * t <= v) res = t;
      end
      return res;
    endfunction

    // Vectoring rotation toward the x axis, angle in 2^32 units per turn.
    function bit [31:0] heading(longint x, longint y);
      longint cx, cy, nx, ny;
      bit [31:0] ang;
      cx = x * 16384;
      cy = y * 16384;
      ang = 0;
      if (cx == 0 && cy == 0) return 0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < 28; i++) begin
        if (cy == 0) break;
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          ang += rot_tab[i];
        end else begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          ang -= rot_tab[i];
        end
        cx = nx;
        cy = ny;
      end
      return ang;
    endfunction

    // Returns the cell index touched by an insert, or -1 for a read.
    function int note_request(logic op, logic signed [16:0] x, logic signed [16:0] y,
                              logic signed [15:0] z, logic [7:0] ssel, logic [7:0] bsel);
      cell_report_t e;
      longint unsigned r2, rng, split, stp, q, prod;
      longint sx, sy;
      bit [31:0] a;
      int c;
      if (op == pgh_pkg::OP_READ) begin
        reads++;
        e.sector = ssel;
        e.bin = bsel;
        if (ssel >= pgh_pkg::NUM_SECTORS || bsel >= pgh_pkg::NUM_BINS) begin
          e.seen = 0; e.min_z = 16'sh7FFF; e.min_range = 0; e.max_z = 16'sh8000;
        end else begin
          c = ssel * pgh_pkg::NUM_BINS + bsel;
          e.seen = hit[c]; e.min_z = low_z[c]; e.min_range = low_rng[c];
          e.max_z = high_z[c];
        end
        pending = {pending, e};
        return -1;
      end
      inserts++;
      sx = x;
      sy = y;
      r2 = sx * sx + sy * sy;
      rng = int_sqrt(r2);
      split = split_radius;
      if (r2 < split * split) begin
        stp = (inner_step == 0) ? 1 : inner_step;
        q = rng / stp;
      end else begin
        stp = (outer_step == 0) ? 1 : outer_step;
        q = pgh_pkg::OUTER_BIN_BASE + (rng - split) / stp;
      end
      if (q > pgh_pkg::NUM_BINS - 1) q = pgh_pkg::NUM_BINS - 1;
      a = heading(sx, sy) + 32'h8000_0000;
      prod = ({32'd0, a} * pgh_pkg::NUM_SECTORS) >> 32;
      if (prod >= pgh_pkg::NUM_SECTORS) prod = pgh_pkg::NUM_SECTORS - 1;
      c = prod * pgh_pkg::NUM_BINS + q;
      hit[c] = 1'b1;
      if (z < low_z[c]) begin
        low_z[c] = z;
        low_rng[c] = rng[16:0];
      end
      if (z > high_z[c]) high_z[c] = z;
      e.sector = prod[7:0]; e.bin = q[7:0]; e.seen = 1'b1;
      e.min_z = low_z[c]; e.min_range = low_rng[c]; e.max_z = high_z[c];
      pending = {pending, e};
      return c;
    endfunction

    function void check_result(cell_report_t got);
      cell_report_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: sector %0d bin %0d",
               got.sector, got.bin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.sector !== e.sector) begin
        $error("sector: expected %0d, got %0d", e.sector, got.sector); errors++;
      end
      if (got.bin !== e.bin) begin
        $error("bin: expected %0d, got %0d", e.bin, got.bin); errors++;
      end
      if (got.seen !== e.seen) begin
        $error("cell_seen: expected %0d, got %0d", e.seen, got.seen); errors++;
      end
      if (got.min_z !== e.min_z) begin
        $error("cell_min_z: expected %0d, got %0d", e.min_z, got.min_z); errors++;
      end
      if (got.min_range !== e.min_range) begin
        $error("cell_min_range: expected %0d, got %0d", e.min_range, got.min_range);
        errors++;
      end
      if (got.max_z !== e.max_z) begin
        $error("cell_max_z: expected %0d, got %0d", e.max_z, got.max_z); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_opcode = pgh_pkg::OP_INSERT;
  logic signed [16:0] in_x_mm = '0;
  logic signed [16:0] in_y_mm = '0;
  logic signed [15:0] in_z_mm = '0;
  logic [7:0]         in_sector_sel = '0;
  logic [7:0]         in_bin_sel = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_addr = pgh_pkg::CFG_INNER_STEP;
  logic [15:0]        cfg_wdata = '0;
  logic               out_valid;
  logic [7:0]         out_sector;
  logic [7:0]         out_bin;
  logic               out_cell_seen;
  logic signed [15:0] out_cell_min_z;
  logic [16:0]        out_cell_min_range;
  logic signed [15:0] out_cell_max_z;

  height_map_scoreboard sb = new();
  int                   idle_cycles = 0;
  int                   touched [$];
  logic signed [16:0]   pool_x [8];
  logic signed [16:0]   pool_y [8];

  localparam int IDLE_LIMIT = 100000;

  always #5 clk = ~clk;

  polar_grid_height_binning u_top (.*);

  always @(posedge clk) begin
    cell_report_t got;
    if (rst_n && out_valid) begin
      got = '{out_sector, out_bin, out_cell_seen, out_cell_min_z,
              out_cell_min_range, out_cell_max_z};
      sb.check_result(got);
    end
  end

  // Watchdog: the post-reset clear, with busy high, stays within its limit.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_request(logic op, logic signed [16:0] x, logic signed [16:0] y,
                              logic signed [15:0] z, logic [7:0] ssel, logic [7:0] bsel,
                              int gap);
    int c;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op; in_x_mm <= x; in_y_mm <= y; in_z_mm <= z;
    in_sector_sel <= ssel; in_bin_sel <= bsel;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    c = sb.note_request(op, x, y, z, ssel, bsel);
    if (c >= 0) touched = {touched, c};
    if (touched.size() > 64) void'(touched.pop_front());
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic insert_pt(int x, int y, int z);
    send_request(pgh_pkg::OP_INSERT, x, y, z, 8'd0, 8'd0, pick_gap());
  endtask

  task automatic read_cell(int s, int b);
    send_request(pgh_pkg::OP_READ, $urandom, $urandom, $urandom, s, b, pick_gap());
  endtask

  task automatic random_phase(int count);
    int r, c, x, y, k;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10 && touched.size() > 0) begin
        c = touched[$urandom_range(0, touched.size() - 1)];
        read_cell(c / pgh_pkg::NUM_BINS, c % pgh_pkg::NUM_BINS);
      end else if (r < 15) begin
        read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        k = $urandom_range(0, 9);
        if (k < 4) begin
          x = $urandom_range(0, 8000) - 4000;
          y = $urandom_range(0, 8000) - 4000;
        end else if (k < 7) begin
          x = $urandom_range(0, 131071) - 65536;
          y = $urandom_range(0, 131071) - 65536;
        end else if (k < 9) begin
          // Repeated points pile several heights into one cell.
          c = $urandom_range(0, 7);
          x = pool_x[c]; y = pool_y[c];
        end else begin
          x = $urandom_range(0, 131071) - 65536;
          case ($urandom_range(0, 3))
            0: y = 0;
            1: begin y = x; x = 0; end
            2: y = x;
            default: y = -x;
          endcase
        end
        insert_pt(x, y, $urandom_range(0, 65535) - 32768);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      pool_x[i] = $urandom_range(0, 131071) - 65536;
      pool_y[i] = $urandom_range(0, 131071) - 65536;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed requests on reset settings.
    insert_pt(0, 0, 100);
    insert_pt(0, 0, 100);
    read_cell(pgh_pkg::NUM_SECTORS / 2, 0);
    insert_pt(100, 100, 32767);
    insert_pt(100, 100, -32768);
    insert_pt(-65536, -65536, 5);
    insert_pt(65535, 65535, -5);
    insert_pt(-65536, 65535, 0);
    insert_pt(65535, -65536, 0);
    insert_pt(-1, 0, 1);
    insert_pt(0, -1, 1);
    insert_pt(19999, 0, 7);
    insert_pt(20000, 0, 7);
    insert_pt(-30000, 1, 3);
    read_cell(179, 159);
    read_cell(180, 0);
    read_cell(0, 160);
    read_cell(255, 255);
    read_cell(0, 0);
    drain();

    random_phase(290);
    drain();
    // The sender waits for every result before each settings change.
    write_reg(pgh_pkg::CFG_INNER_STEP, 16'd1);
    write_reg(pgh_pkg::CFG_SPLIT, 16'd1);
    write_reg(pgh_pkg::CFG_OUTER_STEP, 16'd1);
    random_phase(290);
    drain();
    write_reg(pgh_pkg::CFG_INNER_STEP, 16'd1000);
    write_reg(pgh_pkg::CFG_SPLIT, 16'd65535);
    write_reg(pgh_pkg::CFG_OUTER_STEP, 16'd2000);
    random_phase(290);
    drain();
    // Zero steps act as one and a zero split sends everything to outer bins.
    write_reg(pgh_pkg::CFG_INNER_STEP, 16'd0);
    write_reg(pgh_pkg::CFG_SPLIT, 16'd0);
    write_reg(pgh_pkg::CFG_OUTER_STEP, 16'd0);
    insert_pt(0, 0, -3);
    random_phase(290);
    drain();
    write_reg(pgh_pkg::CFG_INNER_STEP, 16'hFFFF);
    write_reg(pgh_pkg::CFG_SPLIT, 16'd150);
    write_reg(pgh_pkg::CFG_OUTER_STEP, 16'hFFFF);
    random_phase(290);
    drain();
    write_reg(pgh_pkg::CFG_INNER_STEP, $urandom_range(1, 1000));
    write_reg(pgh_pkg::CFG_SPLIT, $urandom_range(1, 65535));
    write_reg(pgh_pkg::CFG_OUTER_STEP, $urandom_range(1, 2000));
    random_phase(290);
    start <= 1'b0;

    fork
      begin
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
      end
      begin
        repeat (20000) @(posedge clk);
        $error("results still outstanding: %0d", sb.pending.size());
        sb.errors++;
      end
    join_any
    disable fork;

    $display("Covered %0d inserts and %0d cell reads over six bin settings, %0d results",
             sb.inserts, sb.reads, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pgh_pkg.sv
rtl/core/pgh_ram.sv
rtl/core/polar_grid_height_binning.sv
test/polar_grid_height_binning_tb.sv
